// ===== src/aip_pkg.sv =====
// Package for the ASCII integer literal parser.
// Holds the parser phase and radix types and the character codes.
// It depends on nothing else.
package aip_pkg;

  typedef enum logic [3:0] {
    PH_START  = 4'b0001,
    PH_SIGNED = 4'b0010,
    PH_ZERO   = 4'b0100,
    PH_DIGITS = 4'b1000
  } phase_t;

  typedef enum logic [1:0] {
    RX_DEC = 2'd0,
    RX_HEX = 2'd1,
    RX_BIN = 2'd2,
    RX_OCT = 2'd3
  } radix_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } item_t;

  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_SEVEN = 8'h37;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_F  = 8'h66;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_F  = 8'h46;
  localparam logic [7:0] CH_LO_X  = 8'h78;
  localparam logic [7:0] CH_UP_X  = 8'h58;
  localparam logic [7:0] CH_LO_B  = 8'h62;
  localparam logic [7:0] CH_UP_B  = 8'h42;

endpackage

// ===== src/ascii_integer_parser_unit.sv =====
// ASCII integer literal parser: one character per transfer, last_char on the final one.
// Accepts an optional '-', then 0x/0X (hex), 0b/0B (binary), a lone leading 0 (octal),
// or decimal, and gives one result per literal: the value wrapped to VALUE_WIDTH bits,
// or 0 with invalid set if a character was not a digit of the base. The block takes a
// character every cycle unless stalled; a character is held in the input register, and the
// result of a final one is registered into the output register. The input side stalls only
// when a final character meets a full output register that is not being taken.
// Depends on aip_pkg and aip_core.
module ascii_integer_parser_unit #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    char_code,
  input  logic                          last_char,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [VALUE_WIDTH-1:0] value,
  output logic                          invalid
);

  aip_pkg::item_t                item;
  logic                          item_valid;
  logic                          step;
  logic                          out_free;
  logic signed [VALUE_WIDTH-1:0] res_value;
  logic                          res_invalid;

  assign out_free = !out_valid || out_ready;
  // Characters that end no literal always move on; a final one needs room at the output.
  assign step     = item_valid && (!item.last_char || out_free);
  assign in_ready = !item_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item.char_code <= char_code;
      item.last_char <= last_char;
    end
  end

  aip_core #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .item        (item),
    .res_value   (res_value),
    .res_invalid (res_invalid)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step && item.last_char) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && item.last_char) begin
      value   <= res_value;
      invalid <= res_invalid;
    end
  end

  a_invalid_is_zero : assert property (@(posedge clk) disable iff (rst)
    out_valid && invalid |-> value == '0)
    else $error("invalid result carries a nonzero value");

  a_stall_cause : assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready && item_valid && item.last_char)
    else $error("input stalled without a blocked final character");

  a_stalled_item_kept : assert property (@(posedge clk) disable iff (rst)
    item_valid && !step |=> item_valid && $stable(item))
    else $error("stalled character lost or changed");

endmodule

// ===== src/aip_digit.sv =====
// Digit decoder for the ASCII integer literal parser.
// Maps one character to a digit value and checks it against the radix.
// Depends on aip_pkg.
module aip_digit (
  input  logic [7:0]      char_code,
  input  aip_pkg::radix_t radix,
  output logic            digit_ok,
  output logic [3:0]      digit
);

  logic       is_num;
  logic       is_hex_letter;
  logic [7:0] offset;

  always_comb begin
    is_num        = char_code inside {[aip_pkg::CH_ZERO : aip_pkg::CH_NINE]};
    is_hex_letter = char_code inside {[aip_pkg::CH_LO_A : aip_pkg::CH_LO_F],
                                      [aip_pkg::CH_UP_A : aip_pkg::CH_UP_F]};
    if (is_num) begin
      offset = char_code - aip_pkg::CH_ZERO;
    end else begin
      // Letters: the low three bits give 1 for 'a'/'A' through 6 for 'f'/'F'.
      offset = {5'd0, char_code[2:0]} + 8'd9;
    end
    digit = offset[3:0];
    case (radix)
      aip_pkg::RX_HEX: digit_ok = is_num || is_hex_letter;
      aip_pkg::RX_BIN: digit_ok = char_code inside {[aip_pkg::CH_ZERO : aip_pkg::CH_ONE]};
      aip_pkg::RX_OCT: digit_ok = char_code inside {[aip_pkg::CH_ZERO : aip_pkg::CH_SEVEN]};
      default:         digit_ok = is_num;
    endcase
  end

endmodule

// ===== src/aip_core.sv =====
// Parser state and per-character update for the ASCII integer literal parser.
// Computes the next state and the result of a literal's last character.
// Depends on aip_pkg and aip_digit.
module aip_core #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          step,
  input  aip_pkg::item_t                item,
  output logic signed [VALUE_WIDTH-1:0] res_value,
  output logic                          res_invalid
);

  aip_pkg::phase_t        phase, phase_next;
  aip_pkg::radix_t        radix, radix_next;
  logic                   negative, negative_next;
  logic [VALUE_WIDTH-1:0] accumulator, accumulator_next;
  logic                   bad_digit, bad_digit_next;
  logic                   take;
  logic                   digit_ok;
  logic [3:0]             digit;
  logic [VALUE_WIDTH-1:0] scaled;
  logic [7:0]             ch;

  assign ch = item.char_code;

  always_comb begin
    phase_next    = phase;
    radix_next    = radix;
    negative_next = negative;
    take          = 1'b0;
    case (phase)
      aip_pkg::PH_START: begin
        if (ch == aip_pkg::CH_MINUS) begin
          negative_next = 1'b1;
          phase_next    = aip_pkg::PH_SIGNED;
        end else if (ch == aip_pkg::CH_ZERO) begin
          phase_next = aip_pkg::PH_ZERO;
        end else begin
          radix_next = aip_pkg::RX_DEC;
          phase_next = aip_pkg::PH_DIGITS;
          take       = 1'b1;
        end
      end
      aip_pkg::PH_SIGNED: begin
        if (ch == aip_pkg::CH_ZERO) begin
          phase_next = aip_pkg::PH_ZERO;
        end else begin
          radix_next = aip_pkg::RX_DEC;
          phase_next = aip_pkg::PH_DIGITS;
          take       = 1'b1;
        end
      end
      aip_pkg::PH_ZERO: begin
        phase_next = aip_pkg::PH_DIGITS;
        if (ch == aip_pkg::CH_LO_X || ch == aip_pkg::CH_UP_X) begin
          radix_next = aip_pkg::RX_HEX;
        end else if (ch == aip_pkg::CH_LO_B || ch == aip_pkg::CH_UP_B) begin
          radix_next = aip_pkg::RX_BIN;
        end else begin
          // A lone leading zero followed by anything else means octal.
          radix_next = aip_pkg::RX_OCT;
          take       = 1'b1;
        end
      end
      aip_pkg::PH_DIGITS: take = 1'b1;
      default:            phase_next = aip_pkg::PH_START;
    endcase
  end

  aip_digit u_digit (
    .char_code (ch),
    .radix     (radix_next),
    .digit_ok  (digit_ok),
    .digit     (digit)
  );

  always_comb begin
    case (radix_next)
      aip_pkg::RX_HEX: scaled = accumulator << 4;
      aip_pkg::RX_BIN: scaled = accumulator << 1;
      aip_pkg::RX_OCT: scaled = accumulator << 3;
      default:         scaled = (accumulator << 3) + (accumulator << 1);
    endcase
    accumulator_next = accumulator;
    bad_digit_next   = bad_digit;
    // Once a bad digit is seen, the rest of the literal is ignored.
    if (take && !bad_digit) begin
      if (digit_ok) begin
        accumulator_next = scaled + {{(VALUE_WIDTH-4){1'b0}}, digit};
      end else begin
        bad_digit_next = 1'b1;
      end
    end
    res_invalid = bad_digit_next;
    if (bad_digit_next) begin
      res_value = '0;
    end else if (negative_next) begin
      res_value = -accumulator_next;
    end else begin
      res_value = accumulator_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (step && item.last_char)) begin
      phase       <= aip_pkg::PH_START;
      radix       <= aip_pkg::RX_DEC;
      negative    <= 1'b0;
      accumulator <= '0;
      bad_digit   <= 1'b0;
    end else if (step) begin
      phase       <= phase_next;
      radix       <= radix_next;
      negative    <= negative_next;
      accumulator <= accumulator_next;
      bad_digit   <= bad_digit_next;
    end
  end

endmodule
